### rtl/modbus_rtu_slave_frame_handler_core_macros.svh
// assertion macros for the modbus rtu slave frame handler
`ifndef MODBUS_RTU_SLAVE_FRAME_HANDLER_CORE_MACROS_SVH
`define MODBUS_RTU_SLAVE_FRAME_HANDLER_CORE_MACROS_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define MBRTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on the rising edge of clk outside reset
`define MBRTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mbrtu_pkg.sv
// shared types and constants of the modbus rtu slave frame handler
`default_nettype none
package mbrtu_pkg;

  localparam int unsigned REG_BYTES_DEF = 2;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0]  FUNC_WRITE_COIL = 8'h05;
  localparam logic [7:0]  FUNC_READ_HOLD  = 8'h03;
  localparam logic [7:0]  COIL_ON         = 8'hFF;
  localparam logic [7:0]  SLAVE_ADDR_RST  = 8'h01;
  localparam logic [15:0] FAN_COIL_ADDR   = 16'd8;
  localparam logic [15:0] LED_COIL_COUNT  = 16'd8;

  localparam logic [2:0]  FRAME_LAST_IDX  = 3'd7;
  localparam logic [2:0]  CRC_RX_LAST_IDX = 3'd5;
  localparam logic [2:0]  BIT_LAST        = 3'd7;

  // input item opcodes
  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_TEMP    = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic [8:0] coil_bits;
  } out_item_t;

  // control of the shared crc unit
  typedef struct packed {
    logic init;
    logic step;
    logic load;
  } crc_ctl_t;

  // fixed fields of a collected request frame
  typedef struct packed {
    logic [7:0]  func;
    logic [15:0] start;
    logic [15:0] count;
    logic [7:0]  crc_lo;
    logic [7:0]  crc_hi;
  } frame_hdr_t;

endpackage
`default_nettype wire

### rtl/modbus_rtu_slave_frame_handler_core.sv
// Received bytes and temperature items are accepted only while the sequencer is idle.
// A completed frame is checked by the bit-serial crc unit over its first six bytes.
// Read replies run the same unit over their 3 to 6 body bytes.
// Reply items, 5 to 8, leave the output register at one per cycle unless out_ready stalls.
// Synchronous reset clears the counters, sequencer, output valid, coils (leds off),
// temperature and restores slave address 1.
`default_nettype none
`include "modbus_rtu_slave_frame_handler_core_macros.svh"
module modbus_rtu_slave_frame_handler_core
  import mbrtu_pkg::*;
#(
  parameter int unsigned REG_BYTES = REG_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  localparam int unsigned LimW = $clog2(REG_BYTES + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CRC_RX = 5'b00010,
    S_CHECK  = 5'b00100,
    S_CRC_TX = 5'b01000,
    S_SEND   = 5'b10000
  } state_t;

  state_t      state;
  logic [2:0]  idx;
  logic [2:0]  bit_idx;
  logic [2:0]  last;
  logic        echo;
  logic [7:0]  led_outputs;
  logic        fan_output;
  logic [7:0]  temperature_byte;
  logic [7:0]  slave_address;

  logic        in_fire;
  logic        rx_fire;
  logic        frame_full;
  logic [7:0]  frame_rd;
  frame_hdr_t  hdr;
  crc_ctl_t    crc_ctl;
  logic [7:0]  crc_data;
  logic [15:0] crc;
  logic [7:0]  reply_byte;
  logic [7:0]  send_byte;
  logic        send_load;
  logic        crc_ok;
  logic [16:0] cnt2;
  logic [LimW-1:0] limit;
  logic [LimW-1:0] diff;
  logic [1:0]  dcnt;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign rx_fire   = in_fire && (in_data.opcode == OP_RX_BYTE);

  mbrtu_frame_buf u_frame_buf (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (rx_fire),
    .wr_data    (in_data.data_byte),
    .rd_idx     (idx),
    .rd_data    (frame_rd),
    .frame_full (frame_full),
    .hdr        (hdr)
  );

  mbrtu_crc_unit u_crc_unit (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (crc_data),
    .crc  (crc)
  );

  // byte k of a read reply body: header then register bytes from start
  always_comb begin
    case (idx)
      3'd0:    reply_byte = slave_address;
      3'd1:    reply_byte = FUNC_READ_HOLD;
      3'd2:    reply_byte = {hdr.count[6:0], 1'b0};
      default: begin
        if (((hdr.start == 16'd0) && (idx == 3'd4)) ||
            ((hdr.start == 16'd1) && (idx == 3'd3))) begin
          reply_byte = temperature_byte;
        end else begin
          reply_byte = 8'h00;
        end
      end
    endcase
  end

  // crc unit control and byte source
  always_comb begin
    crc_ctl.init = (rx_fire && frame_full) ||
                   ((state == S_CHECK) && crc_ok && (hdr.func == FUNC_READ_HOLD));
    crc_ctl.step = (state == S_CRC_RX) || (state == S_CRC_TX);
    crc_ctl.load = (bit_idx == 3'd0);
    crc_data     = (state == S_CRC_RX) ? frame_rd : reply_byte;
  end

  assign crc_ok = (hdr.crc_lo == crc[7:0]) && (hdr.crc_hi == crc[15:8]);

  // number of register bytes in a read reply, at most three
  always_comb begin
    cnt2 = {hdr.count, 1'b0};
    if (cnt2 > 17'(REG_BYTES)) begin
      limit = LimW'(REG_BYTES);
    end else begin
      limit = cnt2[LimW-1:0];
    end
    diff = limit - hdr.start[LimW-1:0];
    if (hdr.start >= 16'(limit)) begin
      dcnt = 2'd0;
    end else if (diff > LimW'(3)) begin
      dcnt = 2'd3;
    end else begin
      dcnt = diff[1:0];
    end
  end

  // outgoing byte: echo, reply body or trailing crc
  always_comb begin
    if (echo) begin
      send_byte = frame_rd;
    end else if (idx == last) begin
      send_byte = crc[15:8];
    end else if (idx == last - 3'd1) begin
      send_byte = crc[7:0];
    end else begin
      send_byte = reply_byte;
    end
  end

  assign send_load = (state == S_SEND) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      bit_idx <= '0;
      last    <= '0;
      echo    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (rx_fire && frame_full) begin
            state   <= S_CRC_RX;
            idx     <= '0;
            bit_idx <= '0;
          end
        end
        S_CRC_RX: begin
          bit_idx <= bit_idx + 3'd1;
          if (bit_idx == BIT_LAST) begin
            idx <= idx + 3'd1;
            if (idx == CRC_RX_LAST_IDX) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          idx     <= '0;
          bit_idx <= '0;
          if (!crc_ok) begin
            state <= S_IDLE;
          end else if (hdr.func == FUNC_WRITE_COIL) begin
            echo  <= 1'b1;
            last  <= FRAME_LAST_IDX;
            state <= S_SEND;
          end else if (hdr.func == FUNC_READ_HOLD) begin
            echo  <= 1'b0;
            last  <= 3'd4 + {1'b0, dcnt};
            state <= S_CRC_TX;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CRC_TX: begin
          bit_idx <= bit_idx + 3'd1;
          if (bit_idx == BIT_LAST) begin
            if (idx == last - 3'd2) begin
              idx   <= '0;
              state <= S_SEND;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        S_SEND: begin
          if (send_load) begin
            idx <= idx + 3'd1;
            if (idx == last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // coil outputs, applied on a good write-coil request
  always_ff @(posedge clk) begin
    if (rst) begin
      led_outputs <= 8'hFF;
      fan_output  <= 1'b0;
    end else if ((state == S_CHECK) && crc_ok && (hdr.func == FUNC_WRITE_COIL)) begin
      if (hdr.start < LED_COIL_COUNT) begin
        led_outputs[hdr.start[2:0]] <= (hdr.count[15:8] != COIL_ON);
      end else if (hdr.start == FAN_COIL_ADDR) begin
        fan_output <= (hdr.count[15:8] == COIL_ON);
      end
    end
  end

  // temperature reading and slave address register
  always_ff @(posedge clk) begin
    if (rst) begin
      temperature_byte <= 8'h00;
      slave_address    <= SLAVE_ADDR_RST;
    end else begin
      if (in_fire && (in_data.opcode == OP_TEMP)) begin
        temperature_byte <= in_data.data_byte;
      end
      if (cfg_valid && cfg_ready) begin
        slave_address <= cfg_data;
      end
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (send_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send_load) begin
      out_data.tx_byte   <= send_byte;
      out_data.last_byte <= (idx == last);
      out_data.coil_bits <= {fan_output, led_outputs};
    end
  end

  // assertions
  `MBRTU_ASSERT_NEXT(a_frame_starts_crc, rx_fire && frame_full, state == S_CRC_RX, "frame end did not start crc check")
  `MBRTU_ASSERT_NOW(a_crc_rx_in_range, state == S_CRC_RX, idx <= CRC_RX_LAST_IDX, "crc check read past byte five")
  `MBRTU_ASSERT_NEXT(a_check_exits, state == S_CHECK, state == S_IDLE || state == S_SEND || state == S_CRC_TX, "check state did not resolve")
  `MBRTU_ASSERT_NEXT(a_last_item_ends, send_load && (idx == last), state == S_IDLE && out_valid && out_data.last_byte, "final reply item did not end the reply")

endmodule
`default_nettype wire

### rtl/mbrtu_crc_unit.sv
// bit-serial crc-16 unit, one polynomial step per cycle while ctl.step is set
`default_nettype none
module mbrtu_crc_unit
  import mbrtu_pkg::*;
(
  input  wire logic        clk,
  input  wire crc_ctl_t    ctl,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc
);

  logic [15:0] mixed;
  logic [15:0] shifted;

  // fold in the byte on its first bit, then one reflected shift
  always_comb begin
    mixed   = ctl.load ? (crc ^ {8'h00, data}) : crc;
    shifted = mixed[0] ? ((mixed >> 1) ^ CRC_POLY) : (mixed >> 1);
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      crc <= CRC_SEED;
    end else if (ctl.step) begin
      crc <= shifted;
    end
  end

endmodule
`default_nettype wire

### rtl/mbrtu_frame_buf.sv
// request frame buffer: eight byte registers and the fill counter
`default_nettype none
module mbrtu_frame_buf
  import mbrtu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_data,
  input  wire logic [2:0] rd_idx,
  output logic      [7:0] rd_data,
  output logic            frame_full,
  output frame_hdr_t      hdr
);

  logic [7:0] frame [8];
  logic [2:0] byte_count;

  // store bytes in arrival order, counter wraps after the eighth
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame[byte_count] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (wr_en) begin
      byte_count <= byte_count + 3'd1;
    end
  end

  // this write completes the frame
  assign frame_full = (byte_count == FRAME_LAST_IDX);

  assign rd_data = frame[rd_idx];

  // fixed taps of the request fields
  always_comb begin
    hdr.func   = frame[1];
    hdr.start  = {frame[2], frame[3]};
    hdr.count  = {frame[4], frame[5]};
    hdr.crc_lo = frame[6];
    hdr.crc_hi = frame[7];
  end

endmodule
`default_nettype wire

### bench/tb_top.sv
// self-checking testbench for the modbus rtu slave frame handler core
`default_nettype none
module tb_top;
  import mbrtu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_TOTAL   = 430;
  localparam int STEADY_ITEMS  = 70;
  localparam int SETTLE_CYCLES = 150;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 400000;

  typedef logic [7:0] frame_bytes_t [8];

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [7:0] cfg_data;

  // expected reply bytes, oldest first
  out_item_t reply_q[$];

  // predicted block state
  frame_bytes_t exp_frame;
  logic [2:0]   exp_fill;
  logic [7:0]   exp_leds;
  logic         exp_fan;
  logic [7:0]   exp_temp;
  logic [7:0]   exp_slave;

  int  mismatches;
  int  items_sent;
  int  cycle_cnt;
  int  hold_req;
  int  hold_ack;
  bit  gaps_on;

  modbus_rtu_slave_frame_handler_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("modbus_rtu_slave_frame_handler_core test failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // crc-16 as used on the wire: reflected, seeded all ones
  function automatic logic [15:0] modbus_crc(frame_bytes_t buf_bytes, int len);
    logic [15:0] crc;
    crc = CRC_SEED;
    for (int i = 0; i < len; i++) begin
      crc ^= {8'h00, buf_bytes[i]};
      for (int b = 0; b < 8; b++) begin
        if (crc[0]) begin
          crc = (crc >> 1) ^ CRC_POLY;
        end else begin
          crc = crc >> 1;
        end
      end
    end
    return crc;
  endfunction

  function automatic void reset_prediction();
    foreach (exp_frame[i]) exp_frame[i] = 8'h00;
    exp_fill  = 3'd0;
    exp_leds  = 8'hFF;
    exp_fan   = 1'b0;
    exp_temp  = 8'h00;
    exp_slave = SLAVE_ADDR_RST;
  endfunction

  // advance the predicted state by one accepted item and queue its reply bytes
  function automatic void predict_reply(in_item_t it);
    frame_bytes_t reply;
    logic [15:0] crc;
    logic [15:0] start;
    logic [15:0] count;
    int          lim;
    int          n;
    out_item_t   r;
    if (it.opcode == OP_TEMP) begin
      exp_temp = it.data_byte;
      return;
    end
    exp_frame[exp_fill] = it.data_byte;
    exp_fill = exp_fill + 3'd1;
    if (exp_fill != 3'd0) return;
    crc = modbus_crc(exp_frame, 6);
    if (exp_frame[6] != crc[7:0] || exp_frame[7] != crc[15:8]) return;
    start = {exp_frame[2], exp_frame[3]};
    count = {exp_frame[4], exp_frame[5]};
    if (exp_frame[1] == FUNC_WRITE_COIL) begin
      // leds are active low, fan active high
      if (start < LED_COIL_COUNT) begin
        exp_leds[start[2:0]] = (exp_frame[4] != COIL_ON);
      end else if (start == FAN_COIL_ADDR) begin
        exp_fan = (exp_frame[4] == COIL_ON);
      end
      reply = exp_frame;
      n = 8;
    end else if (exp_frame[1] == FUNC_READ_HOLD) begin
      lim = 2 * int'(count);
      if (lim > int'(REG_BYTES_DEF)) lim = REG_BYTES_DEF;
      reply[0] = exp_slave;
      reply[1] = FUNC_READ_HOLD;
      reply[2] = 8'(exp_frame[5] * 2);
      n = 3;
      // data bytes packed, capped so crc still fits in eight bytes
      for (int j = int'(start); j < lim && n < 6; j++) begin
        reply[n] = (j == 1) ? exp_temp : 8'h00;
        n++;
      end
      crc = modbus_crc(reply, n);
      reply[n] = crc[7:0];
      reply[n + 1] = crc[15:8];
      n += 2;
    end else begin
      return;
    end
    for (int k = 0; k < n; k++) begin
      r.tx_byte   = reply[k];
      r.last_byte = (k == n - 1);
      r.coil_bits = {exp_fan, exp_leds};
      reply_q.push_back(r);
    end
  endfunction

  // reply checker
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("unexpected reply byte %02h", out_data.tx_byte));
      end else begin
        e = reply_q.pop_front();
        if (out_data.tx_byte !== e.tx_byte)
          report_mismatch($sformatf("tx_byte %02h, expected %02h",
                                    out_data.tx_byte, e.tx_byte));
        if (out_data.last_byte !== e.last_byte)
          report_mismatch($sformatf("last_byte %0b, expected %0b",
                                    out_data.last_byte, e.last_byte));
        if (out_data.coil_bits !== e.coil_bits)
          report_mismatch($sformatf("coil_bits %03h, expected %03h",
                                    out_data.coil_bits, e.coil_bits));
      end
    end
  end

  // receiver: random stalls, plus a long hold when asked
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    hold_ack   = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // send one item, with an occasional idle burst ahead of it
  task automatic send_item(logic op, logic [7:0] d);
    in_item_t it;
    it.opcode    = op;
    it.data_byte = d;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_reply(it);
    items_sent++;
  endtask

  // build a request with a good crc, optionally break one bit
  task automatic send_frame(logic [7:0] a, logic [7:0] f, logic [15:0] w2,
                            logic [15:0] w4, bit corrupt);
    frame_bytes_t fr;
    logic [15:0]  crc;
    fr[0] = a;
    fr[1] = f;
    fr[2] = w2[15:8];
    fr[3] = w2[7:0];
    fr[4] = w4[15:8];
    fr[5] = w4[7:0];
    fr[6] = 8'h00;
    fr[7] = 8'h00;
    crc = modbus_crc(fr, 6);
    fr[6] = crc[7:0];
    fr[7] = crc[15:8];
    if (corrupt) begin
      fr[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < 8; i++) begin
      // temperature updates may land mid-frame
      if ($urandom_range(0, 11) == 0) send_item(OP_TEMP, 8'($urandom()));
      send_item(OP_RX_BYTE, fr[i]);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
  endtask

  // idle before a register write: a bad frame may still be in the crc unit
  task automatic settle_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slave_address(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    exp_slave = v;
  endtask

  // one random request, well-formed most of the time
  task automatic random_frame();
    int          kind;
    logic [15:0] w2;
    logic [15:0] w4;
    int          n;
    while (exp_fill != 3'd0) send_item(OP_RX_BYTE, 8'($urandom()));
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      w2 = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 9)) : 16'($urandom());
      case ($urandom_range(0, 2))
        0:       w4[15:8] = COIL_ON;
        1:       w4[15:8] = 8'h00;
        default: w4[15:8] = 8'($urandom());
      endcase
      w4[7:0] = ($urandom_range(0, 2) == 0) ? 8'($urandom()) : 8'h00;
      send_frame(8'($urandom()), FUNC_WRITE_COIL, w2, w4, 1'b0);
    end else if (kind < 70) begin
      w2 = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom());
      case ($urandom_range(0, 6))
        0:       w4 = 16'($urandom());
        1:       w4 = {8'h00, 8'($urandom())};
        default: w4 = 16'($urandom_range(0, 5));
      endcase
      send_frame(8'($urandom()), FUNC_READ_HOLD, w2, w4, 1'b0);
    end else if (kind < 80) begin
      send_frame(8'($urandom()),
                 ($urandom_range(0, 1) != 0) ? FUNC_READ_HOLD : FUNC_WRITE_COIL,
                 16'($urandom_range(0, 9)), 16'($urandom()), 1'b1);
    end else if (kind < 88) begin
      send_frame(8'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
    end else begin
      // stray bytes; the next request pads to the frame boundary first
      n = $urandom_range(1, 7);
      repeat (n) send_item(OP_RX_BYTE, 8'($urandom()));
    end
  endtask

  // short directed part: temperature extremes, read at reset address, coil, bad crc
  task automatic test_directed_frames();
    send_item(OP_TEMP, 8'hFF);
    send_frame(8'h00, FUNC_READ_HOLD, 16'd0, 16'd1, 1'b0);
    send_frame(8'hFF, FUNC_WRITE_COIL, 16'd7, {COIL_ON, 8'h00}, 1'b0);
    send_item(OP_TEMP, 8'h00);
    send_frame(8'h01, FUNC_WRITE_COIL, FAN_COIL_ADDR, {COIL_ON, 8'h00}, 1'b1);
  endtask

  // slave address at its extremes, a random value and back to the reset value
  task automatic test_config_sweep();
    logic [7:0] vals [4];
    vals[0] = 8'h00;
    vals[1] = 8'hFF;
    vals[2] = 8'($urandom());
    vals[3] = SLAVE_ADDR_RST;
    foreach (vals[i]) begin
      settle_idle();
      write_slave_address(vals[i]);
      send_frame(8'($urandom()), FUNC_READ_HOLD, 16'($urandom_range(0, 2)),
                 16'($urandom_range(1, 3)), 1'b0);
      random_frame();
    end
  endtask

  // receiver holds off long enough that the block backs up into its input
  task automatic test_backpressure();
    wait_drained();
    hold_req++;
    for (int i = 0; i < 4; i++) begin
      send_frame(8'($urandom()), FUNC_WRITE_COIL, 16'($urandom_range(0, 8)),
                 {($urandom_range(0, 1) != 0) ? COIL_ON : 8'h00, 8'h00}, 1'b0);
    end
    send_frame(8'($urandom()), FUNC_READ_HOLD, 16'd0, 16'd4, 1'b0);
    wait_drained();
  endtask

  // bulk random traffic with register changes between phases
  task automatic test_random_traffic();
    int next_cfg;
    next_cfg = items_sent + 90;
    while (items_sent < ITEMS_TOTAL - STEADY_ITEMS) begin
      random_frame();
      if (items_sent >= next_cfg) begin
        settle_idle();
        case ($urandom_range(0, 3))
          0:       write_slave_address(8'h00);
          1:       write_slave_address(8'hFF);
          default: write_slave_address(8'($urandom()));
        endcase
        next_cfg = items_sent + 90;
      end
    end
  endtask

  // closing stretch without idling on either side
  task automatic test_steady_stream();
    gaps_on = 1'b0;
    while (items_sent < ITEMS_TOTAL) random_frame();
    while (exp_fill != 3'd0) send_item(OP_RX_BYTE, 8'($urandom()));
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = 8'h00;
    gaps_on    = 1'b1;
    hold_req   = 0;
    mismatches = 0;
    items_sent = 0;
    cycle_cnt  = 0;
    reset_prediction();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_config_sweep();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("modbus_rtu_slave_frame_handler_core test passed");
    end else begin
      $display("modbus_rtu_slave_frame_handler_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/mbrtu_pkg.sv
rtl/mbrtu_crc_unit.sv
rtl/mbrtu_frame_buf.sv
rtl/modbus_rtu_slave_frame_handler_core.sv
bench/tb_top.sv
